// ----- src/cmt_pkg.sv -----
package cmt_pkg;

    localparam int CountWidth = 16;
    localparam int DivWidth   = 20;
    localparam int CtrlWidth  = 8;

    localparam int CtrlRunBit    = 0;
    localparam int CtrlPresetBit = 1;
    localparam int CtrlCkselBit  = 3;
    localparam int CtrlModeBit   = 6;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_CMP_A   = 2'd0,
        REG_CMP_B   = 2'd1,
        REG_COUNTER = 2'd2,
        REG_CONTROL = 2'd3
    } reg_sel_t;

    typedef enum logic {
        CFG_DIV_SRC0 = 1'b0,
        CFG_DIV_SRC1 = 1'b1
    } cfg_sel_t;

    typedef struct packed {
        logic [1:0]            op;
        logic [1:0]            reg_index;
        logic [CountWidth-1:0] write_data;
    } item_t;

    typedef struct packed {
        logic [CountWidth-1:0] read_data;
        logic                  irq_a;
        logic                  irq_b;
    } result_t;

endpackage

// ----- src/cmt_in_stage.sv -----
module cmt_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_load,
    input  cmt_pkg::item_t in_item,
    input  logic          advance,
    output logic          stage_valid,
    output cmt_pkg::item_t stage_item
);
    import cmt_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            item_reg <= in_item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

// ----- src/cmt_core.sv -----
module cmt_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [cmt_pkg::DivWidth-1:0] cfg_data,
    input  logic                        fire,
    input  cmt_pkg::item_t              item,
    output cmt_pkg::result_t            result
);
    import cmt_pkg::*;

    logic [DivWidth-1:0]   div0_reg;
    logic [DivWidth-1:0]   div1_reg;
    logic [CountWidth-1:0] cmp_a_reg;
    logic [CountWidth-1:0] cmp_a_next;
    logic [CountWidth-1:0] cmp_b_reg;
    logic [CountWidth-1:0] cmp_b_next;
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic [CtrlWidth-1:0]  ctrl_reg;
    logic [CtrlWidth-1:0]  ctrl_next;
    logic [DivWidth-1:0]   presc_reg;
    logic [DivWidth-1:0]   presc_next;

    logic [DivWidth-1:0]   div_sel;
    logic [CountWidth-1:0] count_inc;
    logic [CtrlWidth-1:0]  wr_byte;
    logic                  match_a;
    logic                  match_b;

    assign div_sel   = ctrl_reg[CtrlCkselBit] ? div1_reg : div0_reg;
    assign count_inc = count_reg + CountWidth'(1);
    assign wr_byte   = item.write_data[CtrlWidth-1:0];
    assign match_a   = (cmp_a_reg != '0) && (count_inc == cmp_a_reg);
    assign match_b   = (cmp_b_reg != '0) && (count_inc == cmp_b_reg);

    always_comb
    begin
        cmp_a_next = cmp_a_reg;
        cmp_b_next = cmp_b_reg;
        count_next = count_reg;
        ctrl_next  = ctrl_reg;
        presc_next = presc_reg;
        result     = '0;
        case (op_t'(item.op))
            OP_READ:
            begin
                case (reg_sel_t'(item.reg_index))
                    REG_CMP_A:   result.read_data = cmp_a_reg;
                    REG_CMP_B:   result.read_data = cmp_b_reg;
                    REG_COUNTER: result.read_data = count_reg;
                    default:     result.read_data = {{(CountWidth-CtrlWidth){1'b0}}, ctrl_reg};
                endcase
            end
            OP_WRITE:
            begin
                case (reg_sel_t'(item.reg_index))
                    REG_CMP_A:   cmp_a_next = item.write_data;
                    REG_CMP_B:   cmp_b_next = item.write_data;
                    REG_COUNTER: count_next = item.write_data;
                    default:
                    begin
                        if (wr_byte[CtrlPresetBit])
                        begin
                            count_next = '0;
                            presc_next = '0;
                        end
                        ctrl_next                = wr_byte;
                        ctrl_next[CtrlPresetBit] = 1'b0;
                    end
                endcase
            end
            OP_TICK:
            begin
                if (ctrl_reg[CtrlRunBit] && (div_sel != '0))
                begin
                    if (presc_reg != '0)
                    begin
                        presc_next = presc_reg - DivWidth'(1);
                    end
                    else
                    begin
                        presc_next   = div_sel - DivWidth'(1);
                        count_next   = count_inc;
                        result.irq_a = match_a;
                        result.irq_b = match_b;
                        if (match_a && !ctrl_reg[CtrlModeBit])
                        begin
                            count_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div0_reg  <= DivWidth'(1);
            div1_reg  <= DivWidth'(1);
            cmp_a_reg <= '0;
            cmp_b_reg <= '0;
            count_reg <= '0;
            ctrl_reg  <= '0;
            presc_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_sel_t'(cfg_index))
                    CFG_DIV_SRC0: div0_reg <= cfg_data;
                    default:      div1_reg <= cfg_data;
                endcase
            end
            if (fire)
            begin
                cmp_a_reg <= cmp_a_next;
                cmp_b_reg <= cmp_b_next;
                count_reg <= count_next;
                ctrl_reg  <= ctrl_next;
                presc_reg <= presc_next;
            end
        end
    end

endmodule

// ----- src/cmt_out_stage.sv -----
module cmt_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  cmt_pkg::result_t result,
    input  logic             out_stall,
    output logic             can_load,
    output logic             out_valid,
    output cmt_pkg::result_t out_result
);
    import cmt_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ----- src/compare_match_timer_16bit.sv -----
// channel  | signals                                  | direction
// input    | in_valid, in_stall, op, reg_index, data  | item in
// output   | out_valid, out_stall, read_data, irq_a/b | result out
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data| divisor write
//
// one item per clock while out_stall is low; an item reaches the output by way of the
// input register, then the result register holding the timer step
// rst_n clears control state, counter, compares and control; divisors reset to 1
// a stalled result holds in the result register while the input register still
// advances into it as soon as it drains; cfg_ready is always high
module compare_match_timer_16bit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    op,
    input  logic [1:0]                    reg_index,
    input  logic [cmt_pkg::CountWidth-1:0] write_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cmt_pkg::CountWidth-1:0] read_data,
    output logic                          irq_a,
    output logic                          irq_b,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [cmt_pkg::DivWidth-1:0]   cfg_data
);
    import cmt_pkg::*;

    item_t   in_item;
    item_t   stage_item;
    logic    stage_valid;
    logic    can_load;
    logic    fire;
    logic    in_load;
    result_t step_result;
    result_t out_result;

    assign in_item   = '{op: op, reg_index: reg_index, write_data: write_data};
    assign fire      = stage_valid && can_load;
    assign in_stall  = stage_valid && !can_load;
    assign in_load   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    cmt_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_load     (in_load),
        .in_item     (in_item),
        .advance     (fire),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    cmt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (stage_item),
        .result    (step_result)
    );

    cmt_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .result     (step_result),
        .out_stall  (out_stall),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_result (out_result)
    );

    assign read_data = out_result.read_data;
    assign irq_a     = out_result.irq_a;
    assign irq_b     = out_result.irq_b;

    a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (irq_a || irq_b) |-> read_data == '0)
        else $error("interrupt result carries read data");

    a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("step result lost");

    a_load_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_load |=> stage_valid)
        else $error("accepted item lost");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> !fire)
        else $error("stalled result overwritten");

endmodule
